FILE: rtl/core/array_list_engine_core_defines.svh
// Assertion macros for the array list engine core.
// Used by the top level; needs a clock aclk and reset aresetn in scope.
`ifndef ARRAY_LIST_ENGINE_CORE_DEFINES_SVH
`define ARRAY_LIST_ENGINE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define ALE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define ALE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ALE_ASSERT_NOW(label, ante, cons, msg)
`define ALE_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: rtl/core/ale_pkg.sv
// Package for the array list engine core: command and status codes,
// default sizes and the result struct. No dependencies.
package ale_pkg;

    localparam int DEPTH_DEF     = 32;
    localparam int WORD_BITS_DEF = 32;

    localparam logic [2:0] CMD_APPEND = 3'd0;
    localparam logic [2:0] CMD_INSERT = 3'd1;
    localparam logic [2:0] CMD_DELETE = 3'd2;
    localparam logic [2:0] CMD_FIND   = 3'd3;
    localparam logic [2:0] CMD_DUMP   = 3'd4;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;
    localparam logic [1:0] STATUS_MISS  = 2'd3;

    typedef struct packed {
        logic        valid;
        logic [1:0]  status;
        logic [4:0]  position;
        logic [31:0] data;
        logic [5:0]  fill;
        logic        last;
    } ale_res_t;

endpackage

FILE: rtl/core/array_list_engine_core.sv
// Array list engine core. One command at a time; result register decouples m_ side.
// Append writes in the transfer cycle. Insert/delete read each moved entry, then write
// it; a delete of none skips the walk. Find scans at most fill entries. Dump reads and
// loads each entry in turn, limited by the single registered read port of the entry RAM.
// Reset clears the fill count and control state; the entry RAM is not cleared.
// Top level: ties sequencer and entry RAM, holds the output register.
`include "array_list_engine_core_defines.svh"
module array_list_engine_core #(
    parameter int DEPTH     = ale_pkg::DEPTH_DEF,
    parameter int WORD_BITS = ale_pkg::WORD_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_cmd,
    input  logic signed [31:0] s_value,
    input  logic [5:0]         s_index,
    input  logic [5:0]         s_amount,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic [4:0]         m_position,
    output logic signed [31:0] m_data,
    output logic [5:0]         m_fill,
    output logic               m_last
);

    localparam int AW = $clog2(DEPTH);

    ale_pkg::ale_res_t    res;
    logic                 out_free;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [AW-1:0]        mem_raddr;
    logic [WORD_BITS-1:0] mem_rdata;

    logic                 m_valid_reg;
    logic [1:0]           status_reg;
    logic [4:0]           position_reg;
    logic [31:0]          data_reg;
    logic [5:0]           fill_reg;
    logic                 last_reg;

    assign out_free = !m_valid_reg || m_ready;

    ale_seq #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_cmd     (s_cmd),
        .s_value   (s_value),
        .s_index   (s_index),
        .s_amount  (s_amount),
        .out_free  (out_free),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    ale_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_entries (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res.valid && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.valid && out_free) begin
            status_reg   <= res.status;
            position_reg <= res.position;
            data_reg     <= res.data;
            fill_reg     <= res.fill;
            last_reg     <= res.last;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_status   = status_reg;
    assign m_position = position_reg;
    assign m_data     = signed'(data_reg);
    assign m_fill     = fill_reg;
    assign m_last     = last_reg;

    `ALE_ASSERT_NEXT(a_one_cmd_at_a_time, s_valid && s_ready, !s_ready, "command taken while busy")
    `ALE_ASSERT_NOW(a_idle_no_result, s_ready, !res.valid, "result pending while idle")
    `ALE_ASSERT_NOW(a_error_zero_payload, m_valid && (m_status != ale_pkg::STATUS_OK), (m_data == 32'sd0) && (m_position == 5'd0) && m_last, "error result carries payload")

endmodule

FILE: rtl/core/ale_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ale_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/ale_seq.sv
// Command sequencer of the array list engine: checks commands, walks the
// entry RAM for insert, delete, find and dump, and holds the fill count.
// Depends on ale_pkg.
module ale_seq #(
    parameter int DEPTH     = ale_pkg::DEPTH_DEF,
    parameter int WORD_BITS = ale_pkg::WORD_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [2:0]               s_cmd,
    input  logic signed [31:0]       s_value,
    input  logic [5:0]               s_index,
    input  logic [5:0]               s_amount,
    input  logic                     out_free,
    output ale_pkg::ale_res_t        res,
    output logic                     mem_we,
    output logic [$clog2(DEPTH)-1:0] mem_waddr,
    output logic [WORD_BITS-1:0]     mem_wdata,
    output logic [$clog2(DEPTH)-1:0] mem_raddr,
    input  logic [WORD_BITS-1:0]     mem_rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS,
        ST_DEL,
        ST_FIND,
        ST_DUMP_RD,
        ST_DUMP_LD,
        ST_RESP
    } state_t;

    state_t               state_reg, state_next;
    logic [CW-1:0]        fill_reg, fill_next;
    logic                 pend_reg, pend_next;
    logic [AW-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0]        rd_left_reg, rd_left_next;
    logic [WORD_BITS-1:0] val_reg, val_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic [CW-1:0]        amt_reg, amt_next;
    logic [1:0]           status_reg, status_next;
    logic [AW-1:0]        pos_reg, pos_next;

    logic [63:0]          in_wide;
    logic [63:0]          rd_wide;
    logic [WORD_BITS-1:0] in_val;
    logic [SW-1:0]        idx_w, amt_w, fill_w;
    logic                 full;

    assign in_wide = 64'(s_value);
    assign in_val  = in_wide[WORD_BITS-1:0];
    assign rd_wide = 64'(mem_rdata);
    assign idx_w   = SW'(s_index);
    assign amt_w   = SW'(s_amount);
    assign fill_w  = SW'(fill_reg);
    assign full    = (fill_reg == CW'(DEPTH));
    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        pend_next    = pend_reg;
        rd_ptr_next  = rd_ptr_reg;
        wr_ptr_next  = wr_ptr_reg;
        rd_left_next = rd_left_reg;
        val_next     = val_reg;
        idx_next     = idx_reg;
        amt_next     = amt_reg;
        status_next  = status_reg;
        pos_next     = pos_reg;
        mem_we       = 1'b0;
        mem_waddr    = wr_ptr_reg;
        mem_wdata    = mem_rdata;
        mem_raddr    = rd_ptr_reg;
        res          = '0;
        res.fill     = 6'(fill_reg);

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    status_next = ale_pkg::STATUS_OK;
                    pos_next    = '0;
                    pend_next   = 1'b0;
                    state_next  = ST_RESP;
                    unique case (s_cmd)
                        ale_pkg::CMD_APPEND: begin
                            if (full) begin
                                status_next = ale_pkg::STATUS_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = AW'(fill_reg);
                                mem_wdata = in_val;
                                fill_next = fill_reg + 1'b1;
                            end
                        end
                        ale_pkg::CMD_INSERT: begin
                            if (full) begin
                                status_next = ale_pkg::STATUS_FULL;
                            end else if (idx_w > fill_w) begin
                                status_next = ale_pkg::STATUS_RANGE;
                            end else begin
                                val_next     = in_val;
                                idx_next     = AW'(s_index);
                                rd_ptr_next  = AW'(fill_w - 1'b1);
                                wr_ptr_next  = AW'(fill_reg);
                                rd_left_next = CW'(fill_w - idx_w);
                                state_next   = ST_INS;
                            end
                        end
                        ale_pkg::CMD_DELETE: begin
                            if (idx_w + amt_w > fill_w) begin
                                status_next = ale_pkg::STATUS_RANGE;
                            end else if (s_amount != 6'd0) begin
                                rd_ptr_next  = AW'(idx_w + amt_w);
                                wr_ptr_next  = AW'(s_index);
                                rd_left_next = CW'(fill_w - idx_w - amt_w);
                                amt_next     = CW'(s_amount);
                                state_next   = ST_DEL;
                            end
                        end
                        ale_pkg::CMD_FIND: begin
                            val_next     = in_val;
                            rd_ptr_next  = '0;
                            rd_left_next = fill_reg;
                            state_next   = ST_FIND;
                        end
                        ale_pkg::CMD_DUMP: begin
                            if (fill_reg != '0) begin
                                rd_ptr_next  = '0;
                                rd_left_next = fill_reg;
                                state_next   = ST_DUMP_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_INS: begin
                // read entry i-1, write it to i in the next cycle
                mem_we = pend_reg;
                if (pend_reg) begin
                    wr_ptr_next = wr_ptr_reg - 1'b1;
                end
                if (rd_left_reg != '0) begin
                    rd_ptr_next  = rd_ptr_reg - 1'b1;
                    rd_left_next = rd_left_reg - 1'b1;
                    pend_next    = 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        mem_we      = 1'b1;
                        mem_waddr   = idx_reg;
                        mem_wdata   = val_reg;
                        fill_next   = fill_reg + 1'b1;
                        status_next = ale_pkg::STATUS_OK;
                        state_next  = ST_RESP;
                    end
                end
            end
            ST_DEL: begin
                mem_we = pend_reg;
                if (pend_reg) begin
                    wr_ptr_next = wr_ptr_reg + 1'b1;
                end
                if (rd_left_reg != '0) begin
                    rd_ptr_next  = rd_ptr_reg + 1'b1;
                    rd_left_next = rd_left_reg - 1'b1;
                    pend_next    = 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        fill_next   = fill_reg - amt_reg;
                        status_next = ale_pkg::STATUS_OK;
                        state_next  = ST_RESP;
                    end
                end
            end
            ST_FIND: begin
                // wr_ptr holds the index of the word in flight
                if (pend_reg && (mem_rdata == val_reg)) begin
                    pend_next   = 1'b0;
                    pos_next    = wr_ptr_reg;
                    status_next = ale_pkg::STATUS_OK;
                    state_next  = ST_RESP;
                end else if (rd_left_reg != '0) begin
                    wr_ptr_next  = rd_ptr_reg;
                    rd_ptr_next  = rd_ptr_reg + 1'b1;
                    rd_left_next = rd_left_reg - 1'b1;
                    pend_next    = 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        status_next = ale_pkg::STATUS_MISS;
                        state_next  = ST_RESP;
                    end
                end
            end
            ST_DUMP_RD: begin
                if (out_free) begin
                    state_next = ST_DUMP_LD;
                end
            end
            ST_DUMP_LD: begin
                res.valid    = 1'b1;
                res.status   = ale_pkg::STATUS_OK;
                res.position = 5'(rd_ptr_reg);
                res.data     = rd_wide[31:0];
                res.last     = (rd_left_reg == CW'(1));
                rd_ptr_next  = rd_ptr_reg + 1'b1;
                rd_left_next = rd_left_reg - 1'b1;
                state_next   = (rd_left_reg == CW'(1)) ? ST_IDLE : ST_DUMP_RD;
            end
            ST_RESP: begin
                res.valid    = 1'b1;
                res.status   = status_reg;
                res.position = 5'(pos_reg);
                res.last     = 1'b1;
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_ptr_reg  <= rd_ptr_next;
        wr_ptr_reg  <= wr_ptr_next;
        rd_left_reg <= rd_left_next;
        val_reg     <= val_next;
        idx_reg     <= idx_next;
        amt_reg     <= amt_next;
        status_reg  <= status_next;
        pos_reg     <= pos_next;
    end

endmodule

FILE: bench/array_list_engine_core_tb.sv
// Self-checking bench for array_list_engine_core: directed table, fill-up, then random.
// Predicts untyped results from a copy of the list; needs ale_pkg and the core RTL.
`timescale 1ns / 100ps
module array_list_engine_core_tb;

    localparam int DEPTH = ale_pkg::DEPTH_DEF;
    localparam int RANDOM_ITEMS = 40;
    localparam int PLAN_ROWS = 25;

    localparam logic [2:0] CMD_RSVD5 = 3'd5;
    localparam logic [2:0] CMD_RSVD6 = 3'd6;
    localparam logic [2:0] CMD_RSVD7 = 3'd7;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  position;
        logic [31:0] data;
        logic [5:0]  fill;
        logic        last;
    } list_result_t;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] value;
        logic [5:0]  index;
        logic [5:0]  amount;
        logic        typed;
        logic [1:0]  status;
        logic [5:0]  fill;
    } plan_row_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [2:0]         s_cmd;
    logic signed [31:0] s_value;
    logic [5:0]         s_index;
    logic [5:0]         s_amount;
    logic               m_valid;
    logic               m_ready;
    logic [1:0]         m_status;
    logic [4:0]         m_position;
    logic signed [31:0] m_data;
    logic [5:0]         m_fill;
    logic               m_last;

    logic [31:0]  list_words [DEPTH];
    int           list_fill;
    list_result_t predicted [$];
    list_result_t pending_results [$];
    plan_row_t    plan [PLAN_ROWS];
    int           mismatches;
    int           send_quiet;
    int           recv_quiet;

    array_list_engine_core dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_cmd      (s_cmd),
        .s_value    (s_value),
        .s_index    (s_index),
        .s_amount   (s_amount),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_status   (m_status),
        .m_position (m_position),
        .m_data     (m_data),
        .m_fill     (m_fill),
        .m_last     (m_last)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    function automatic list_result_t make_result(logic [1:0] status, int pos,
                                                 logic [31:0] data, bit last);
        list_result_t r;
        r.status   = status;
        r.position = 5'(pos);
        r.data     = data;
        r.fill     = 6'(list_fill);
        r.last     = last;
        return r;
    endfunction

    // Updates the list copy and leaves the results of one command in predicted.
    function automatic void apply_command(logic [2:0] cmd, logic [31:0] val,
                                          logic [5:0] idx, logic [5:0] amt);
        int n;
        bit hit;
        predicted.delete();
        case (cmd)
            ale_pkg::CMD_APPEND: begin
                if (list_fill >= DEPTH) begin
                    predicted.push_back(make_result(ale_pkg::STATUS_FULL, 0, '0, 1'b1));
                end else begin
                    list_words[list_fill] = val;
                    list_fill++;
                    predicted.push_back(make_result(ale_pkg::STATUS_OK, 0, '0, 1'b1));
                end
            end
            ale_pkg::CMD_INSERT: begin
                if (list_fill >= DEPTH) begin
                    predicted.push_back(make_result(ale_pkg::STATUS_FULL, 0, '0, 1'b1));
                end else if (int'(idx) > list_fill) begin
                    predicted.push_back(make_result(ale_pkg::STATUS_RANGE, 0, '0, 1'b1));
                end else begin
                    for (n = list_fill; n > int'(idx); n--)
                        list_words[n] = list_words[n - 1];
                    list_words[idx] = val;
                    list_fill++;
                    predicted.push_back(make_result(ale_pkg::STATUS_OK, 0, '0, 1'b1));
                end
            end
            ale_pkg::CMD_DELETE: begin
                if (int'(idx) + int'(amt) > list_fill) begin
                    predicted.push_back(make_result(ale_pkg::STATUS_RANGE, 0, '0, 1'b1));
                end else begin
                    for (n = int'(idx); n + int'(amt) < list_fill; n++)
                        list_words[n] = list_words[n + int'(amt)];
                    list_fill -= int'(amt);
                    predicted.push_back(make_result(ale_pkg::STATUS_OK, 0, '0, 1'b1));
                end
            end
            ale_pkg::CMD_FIND: begin
                hit = 1'b0;
                for (n = 0; n < list_fill && !hit; n++) begin
                    if (list_words[n] == val) begin
                        hit = 1'b1;
                        predicted.push_back(make_result(ale_pkg::STATUS_OK, n, '0, 1'b1));
                    end
                end
                if (!hit)
                    predicted.push_back(make_result(ale_pkg::STATUS_MISS, 0, '0, 1'b1));
            end
            ale_pkg::CMD_DUMP: begin
                if (list_fill == 0)
                    predicted.push_back(make_result(ale_pkg::STATUS_OK, 0, '0, 1'b1));
                for (n = 0; n < list_fill; n++)
                    predicted.push_back(make_result(ale_pkg::STATUS_OK, n, list_words[n],
                                                    n + 1 == list_fill));
            end
            default: predicted.push_back(make_result(ale_pkg::STATUS_OK, 0, '0, 1'b1));
        endcase
    endfunction

    // Wait length per transfer, with occasional runs of back-to-back transfers.
    function automatic int draw_wait(ref int quiet);
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            quiet = $urandom_range(5, 20);
        return $urandom_range(0, 17);
    endfunction

    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7fff_ffff;
                2: return 32'hffff_ffff;
                default: return 32'h0;
            endcase
        end
        if (r < 3 && list_fill > 0)
            return list_words[$urandom_range(0, list_fill - 1)];
        return $urandom;
    endfunction

    task automatic issue(logic [2:0] cmd, logic [31:0] val, logic [5:0] idx,
                         logic [5:0] amt, bit drain, bit typed, list_result_t typed_res);
        int gap;
        gap = draw_wait(send_quiet);
        @(negedge aclk);
        if (drain || gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
            if (drain) begin
                do @(negedge aclk); while (pending_results.size() != 0);
            end
        end
        s_valid  <= 1'b1;
        s_cmd    <= cmd;
        s_value  <= val;
        s_index  <= idx;
        s_amount <= amt;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        apply_command(cmd, val, idx, amt);
        if (typed)
            pending_results.push_back(typed_res);
        else
            foreach (predicted[k]) pending_results.push_back(predicted[k]);
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin : watch_results
        list_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: transfer with nothing expected, status %0d position %0d",
                         $time, m_status, m_position);
                $display("%0t: data %h fill %0d last %0b", $time, m_data, m_fill, m_last);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", want.status, m_status);
                check_field("position", want.position, m_position);
                check_field("data", want.data, m_data);
                check_field("fill", want.fill, m_fill);
                check_field("last", want.last, m_last);
            end
        end
    end

    initial begin : drain_results
        int gap;
        m_ready = 1'b0;
        forever begin
            gap = draw_wait(recv_quiet);
            @(negedge aclk);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(aresetn && m_valid));
        end
    end

    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin : drive_commands
        logic [2:0]  cmd;
        logic [31:0] val;
        logic [5:0]  idx;
        logic [5:0]  amt;
        int          r;
        int          room;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_cmd      = ale_pkg::CMD_APPEND;
        s_value    = '0;
        s_index    = '0;
        s_amount   = '0;
        list_fill  = 0;
        mismatches = 0;
        send_quiet = 0;
        recv_quiet = 0;
        // typed rows: status and fill, position and data zero, last set
        plan = '{
            '{ale_pkg::CMD_DUMP,   32'h0,         6'd0,  6'd0,  1'b1, ale_pkg::STATUS_OK,    6'd0},
            '{ale_pkg::CMD_FIND,   32'h0,         6'd0,  6'd0,  1'b1, ale_pkg::STATUS_MISS,  6'd0},
            '{ale_pkg::CMD_DELETE, 32'h0,         6'd0,  6'd0,  1'b1, ale_pkg::STATUS_OK,    6'd0},
            '{ale_pkg::CMD_DELETE, 32'h0,         6'd0,  6'd1,  1'b1, ale_pkg::STATUS_RANGE, 6'd0},
            '{ale_pkg::CMD_INSERT, 32'h1,         6'd1,  6'd0,  1'b1, ale_pkg::STATUS_RANGE, 6'd0},
            '{ale_pkg::CMD_INSERT, 32'h8000_0000, 6'd0,  6'd0,  1'b1, ale_pkg::STATUS_OK,    6'd1},
            '{ale_pkg::CMD_APPEND, 32'h7fff_ffff, 6'd0,  6'd0,  1'b1, ale_pkg::STATUS_OK,    6'd2},
            '{ale_pkg::CMD_APPEND, 32'h0,         6'd0,  6'd0,  1'b1, ale_pkg::STATUS_OK,    6'd3},
            '{ale_pkg::CMD_APPEND, 32'hffff_ffff, 6'd0,  6'd0,  1'b1, ale_pkg::STATUS_OK,    6'd4},
            '{ale_pkg::CMD_INSERT, 32'h5,         6'd4,  6'd0,  1'b1, ale_pkg::STATUS_OK,    6'd5},
            '{ale_pkg::CMD_INSERT, 32'h5a5a_5a5a, 6'd2,  6'd0,  1'b1, ale_pkg::STATUS_OK,    6'd6},
            '{ale_pkg::CMD_INSERT, 32'ha5a5_a5a5, 6'd63, 6'd0,  1'b1, ale_pkg::STATUS_RANGE, 6'd6},
            '{ale_pkg::CMD_FIND,   32'hffff_ffff, 6'd0,  6'd0,  1'b0, ale_pkg::STATUS_OK,    6'd0},
            '{ale_pkg::CMD_FIND,   32'h8000_0000, 6'd0,  6'd0,  1'b0, ale_pkg::STATUS_OK,    6'd0},
            '{ale_pkg::CMD_FIND,   32'h0001_2345, 6'd0,  6'd0,  1'b1, ale_pkg::STATUS_MISS,  6'd6},
            '{ale_pkg::CMD_DUMP,   32'h0,         6'd0,  6'd0,  1'b0, ale_pkg::STATUS_OK,    6'd0},
            '{ale_pkg::CMD_DELETE, 32'h0,         6'd1,  6'd2,  1'b1, ale_pkg::STATUS_OK,    6'd4},
            '{ale_pkg::CMD_DELETE, 32'h0,         6'd63, 6'd63, 1'b1, ale_pkg::STATUS_RANGE, 6'd4},
            '{ale_pkg::CMD_DELETE, 32'h0,         6'd2,  6'd3,  1'b1, ale_pkg::STATUS_RANGE, 6'd4},
            '{ale_pkg::CMD_DELETE, 32'h0,         6'd4,  6'd0,  1'b1, ale_pkg::STATUS_OK,    6'd4},
            '{CMD_RSVD5,           32'h1234_5678, 6'd1,  6'd1,  1'b0, ale_pkg::STATUS_OK,    6'd0},
            '{CMD_RSVD6,           32'h0,         6'd0,  6'd0,  1'b0, ale_pkg::STATUS_OK,    6'd0},
            '{CMD_RSVD7,           32'hffff_ffff, 6'd63, 6'd63, 1'b0, ale_pkg::STATUS_OK,    6'd0},
            '{ale_pkg::CMD_DUMP,   32'h0,         6'd0,  6'd0,  1'b0, ale_pkg::STATUS_OK,    6'd0},
            '{ale_pkg::CMD_DELETE, 32'h0,         6'd0,  6'd4,  1'b1, ale_pkg::STATUS_OK,    6'd0}
        };
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (plan[k])
            issue(plan[k].cmd, plan[k].value, plan[k].index, plan[k].amount, 1'b0,
                  plan[k].typed, '{plan[k].status, 5'd0, 32'd0, plan[k].fill, 1'b1});

        // fill to capacity, then hit the full store from every side
        for (int k = 0; k < DEPTH; k++) begin
            if (k % 3 == 1)
                issue(ale_pkg::CMD_INSERT, pick_value(), 6'($urandom_range(0, list_fill)),
                      6'd0, 1'b0, 1'b0, '0);
            else
                issue(ale_pkg::CMD_APPEND, pick_value(), 6'd0, 6'd0, 1'b0, 1'b0, '0);
        end
        issue(ale_pkg::CMD_APPEND, pick_value(), 6'd0, 6'd0, 1'b0, 1'b1,
              '{ale_pkg::STATUS_FULL, 5'd0, 32'd0, 6'd32, 1'b1});
        issue(ale_pkg::CMD_INSERT, pick_value(), 6'd0, 6'd0, 1'b0, 1'b1,
              '{ale_pkg::STATUS_FULL, 5'd0, 32'd0, 6'd32, 1'b1});
        issue(ale_pkg::CMD_INSERT, pick_value(), 6'd63, 6'd0, 1'b0, 1'b1,
              '{ale_pkg::STATUS_FULL, 5'd0, 32'd0, 6'd32, 1'b1});
        issue(ale_pkg::CMD_FIND, list_words[DEPTH - 1], 6'd0, 6'd0, 1'b0, 1'b0, '0);
        issue(ale_pkg::CMD_DUMP, 32'h0, 6'd0, 6'd0, 1'b1, 1'b0, '0);
        issue(ale_pkg::CMD_DELETE, 32'h0, 6'd0, 6'd32, 1'b0, 1'b1,
              '{ale_pkg::STATUS_OK, 5'd0, 32'd0, 6'd0, 1'b1});

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            r = $urandom_range(0, 99);
            if (r < 28)      cmd = ale_pkg::CMD_APPEND;
            else if (r < 48) cmd = ale_pkg::CMD_INSERT;
            else if (r < 66) cmd = ale_pkg::CMD_DELETE;
            else if (r < 84) cmd = ale_pkg::CMD_FIND;
            else if (r < 93) cmd = ale_pkg::CMD_DUMP;
            else if (r < 95) cmd = CMD_RSVD5;
            else if (r < 97) cmd = CMD_RSVD6;
            else             cmd = CMD_RSVD7;
            val = pick_value();
            if ($urandom_range(0, 7) == 0)
                idx = 6'($urandom_range(0, 63));
            else
                idx = 6'($urandom_range(0, list_fill));
            room = list_fill - int'(idx);
            if (room < 0)
                room = 0;
            if ($urandom_range(0, 7) == 0)
                amt = 6'($urandom_range(0, 63));
            else
                amt = 6'($urandom_range(0, room > 6 ? 6 : room));
            issue(cmd, val, idx, amt, (k % 25) == 12, 1'b0, '0);
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
